FILE: design/vabd_pkg.sv
`default_nettype none
package vabd_pkg;

   localparam int TapsLog2 = 3;
   localparam int Taps = 1 << TapsLog2;
   localparam int SampleBits = 10;
   localparam int SumBits = SampleBits + TapsLog2;
   localparam int TenthsBits = 9;
   localparam int ProdBits = 19;
   localparam int PortBits = 8;
   localparam int NumDigits = 3;

   localparam logic [8:0] ScaleTenths = 9'd300;
   localparam logic [9:0] FullScale = 10'd1023;

   localparam logic [PortBits-1:0] SelUnits = 8'hE0;
   localparam logic [PortBits-1:0] SelTens = 8'hD0;
   localparam logic [PortBits-1:0] SelHundreds = 8'hB0;
   localparam logic [PortBits-1:0] DigitReset = 8'h0F;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef struct packed {
      logic req_type;
      logic [SampleBits-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic [PortBits-1:0] port_value;
      logic [SampleBits-1:0] average;
      logic [TenthsBits-1:0] tenths;
   } rsp_payload_type;

   // chain control: shift one place, or seed every cell with the sample
   typedef struct packed {
      logic shift;
      logic seed;
   } chain_ctl_type;

endpackage
`default_nettype wire

FILE: design/vabd_tap_cell.sv
`default_nettype none
module vabd_tap_cell (
   input wire logic clock,
   input wire vabd_pkg::chain_ctl_type ctl,
   input wire logic [vabd_pkg::SampleBits-1:0] seed_sample,
   input wire logic [vabd_pkg::SampleBits-1:0] prev_sample,
   output logic [vabd_pkg::SampleBits-1:0] tap_sample
);

   logic [vabd_pkg::SampleBits-1:0] tap_ff;
   logic [vabd_pkg::SampleBits-1:0] tap_in;

   always_comb begin
      tap_in = tap_ff;
      if (ctl.seed) begin
         tap_in = seed_sample;
      end else if (ctl.shift) begin
         tap_in = prev_sample;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff <= tap_in;
   end

   assign tap_sample = tap_ff;

endmodule
`default_nettype wire

FILE: design/vabd_tap_chain.sv
`default_nettype none
module vabd_tap_chain (
   input wire logic clock,
   input wire logic reset,
   input wire logic sample_take,
   input wire logic [vabd_pkg::SampleBits-1:0] sample,
   output logic [vabd_pkg::SumBits-1:0] sum_next
);

   logic [vabd_pkg::SampleBits-1:0] taps [vabd_pkg::Taps];
   logic [vabd_pkg::SumBits-1:0] sum_ff;
   logic [vabd_pkg::SumBits-1:0] sum_in;
   logic primed_ff;
   logic primed_in;
   vabd_pkg::chain_ctl_type ctl;

   always_comb begin
      ctl.shift = sample_take && primed_ff;
      ctl.seed = sample_take && !primed_ff;
   end

   genvar k;
   generate
      for (k = 0; k < vabd_pkg::Taps; k++) begin : g_cell
         if (k == 0) begin : g_head
            vabd_tap_cell u_cell (
               .clock(clock),
               .ctl(ctl),
               .seed_sample(sample),
               .prev_sample(sample),
               .tap_sample(taps[k])
            );
         end else begin : g_body
            vabd_tap_cell u_cell (
               .clock(clock),
               .ctl(ctl),
               .seed_sample(sample),
               .prev_sample(taps[k-1]),
               .tap_sample(taps[k])
            );
         end
      end
   endgenerate

   // last cell holds the sample that drops out of the window
   always_comb begin
      sum_in = sum_ff;
      primed_in = primed_ff;
      if (ctl.seed) begin
         sum_in = {{vabd_pkg::TapsLog2{1'b0}}, sample} << vabd_pkg::TapsLog2;
         primed_in = 1'b1;
      end else if (ctl.shift) begin
         sum_in = sum_ff - {{vabd_pkg::TapsLog2{1'b0}}, taps[vabd_pkg::Taps-1]}
                  + {{vabd_pkg::TapsLog2{1'b0}}, sample};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         primed_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         primed_ff <= primed_in;
      end
   end

   assign sum_next = sum_in;

endmodule
`default_nettype wire

FILE: design/voltmeter_average_bcd_display.sv
// a result passes the average, product, quotient, digit and response registers in order
// throughput: one transaction per cycle if unstalled, set by the running sum over the tap
// chain and the four-stage scaling pipe (multiply, divide by 1023, digit split, scan)
// a stalled result still lets transactions enter while pipe stages are empty
// reset: synchronous; clears sum, pipe valids, digit codes to 0x0f, scan and driven code
`default_nettype none
module voltmeter_average_bcd_display (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire vabd_pkg::req_payload_type req_payload,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output vabd_pkg::rsp_payload_type rsp_payload
);

   localparam int AvgBits = vabd_pkg::SampleBits;
   localparam int TB = vabd_pkg::TenthsBits;

   logic req_take;
   logic [vabd_pkg::SumBits-1:0] sum_next;

   // stage valids and readiness
   logic v1_ff, v2_ff, v3_ff, v4_ff, out_v_ff;
   logic v1_in, v2_in, v3_in, v4_in, out_v_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy_out;

   // stage payloads
   logic t1_ff, t2_ff, t3_ff, t4_ff;
   logic [AvgBits-1:0] a1_ff, a2_ff, a3_ff, a4_ff;
   logic [vabd_pkg::ProdBits-1:0] p2_ff, p2_in;
   logic [TB-1:0] q3_ff, q3_in, q4_ff;
   logic [3:0] units4_ff, tens4_ff, units4_in, tens4_in;
   logic [1:0] hund4_ff, hund4_in;

   // display state
   logic [vabd_pkg::PortBits-1:0] codes_ff [vabd_pkg::NumDigits];
   logic [vabd_pkg::PortBits-1:0] codes_in [vabd_pkg::NumDigits];
   logic [1:0] scan_ff, scan_in, scan_pick;
   logic [vabd_pkg::PortBits-1:0] driven_ff, driven_in;
   vabd_pkg::rsp_payload_type rsp_ff, rsp_in;

   assign rdy_out = !out_v_ff || rsp_ready;
   assign rdy4 = !v4_ff || rdy_out;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_ready = rdy1;
   assign req_take = req_valid && rdy1;

   vabd_tap_chain u_chain (
      .clock(clock),
      .reset(reset),
      .sample_take(req_take && (req_payload.req_type == vabd_pkg::REQ_SAMPLE)),
      .sample(req_payload.sample),
      .sum_next(sum_next)
   );

   assign v1_in = rdy1 ? req_take : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;
   assign out_v_in = rdy_out ? v4_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         out_v_ff <= out_v_in;
      end
   end

   // scale: avg * 300
   assign p2_in = vabd_pkg::ProdBits'({9'd0, a1_ff} * {10'd0, vabd_pkg::ScaleTenths});

   // divide by 1023: p = 1024*q0 + b, so p = 1023*q0 + (b + q0) with the rest below 2*1023
   logic [TB-1:0] q0;
   logic [10:0] rest;
   always_comb begin
      q0 = p2_ff[vabd_pkg::ProdBits-1:10];
      rest = {1'b0, p2_ff[9:0]} + {2'b00, q0};
      q3_in = (rest >= {1'b0, vabd_pkg::FullScale}) ? q0 + 1'b1 : q0;
   end

   // decimal split, tens by reciprocal multiply (valid below 1029)
   logic [6:0] below_100;
   logic [14:0] tens_prod;
   always_comb begin
      if (q3_ff >= 9'd300) begin
         hund4_in = 2'd3;
         below_100 = 7'(q3_ff - 9'd300);
      end else if (q3_ff >= 9'd200) begin
         hund4_in = 2'd2;
         below_100 = 7'(q3_ff - 9'd200);
      end else if (q3_ff >= 9'd100) begin
         hund4_in = 2'd1;
         below_100 = 7'(q3_ff - 9'd100);
      end else begin
         hund4_in = 2'd0;
         below_100 = 7'(q3_ff);
      end
      tens_prod = {8'd0, below_100} * 15'd205;
      tens4_in = tens_prod[14:11];
      units4_in = 4'(below_100 - 7'({3'd0, tens4_in} * 7'd10));
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         t1_ff <= req_payload.req_type;
         a1_ff <= sum_next[vabd_pkg::SumBits-1:vabd_pkg::TapsLog2];
      end
      if (rdy2) begin
         t2_ff <= t1_ff;
         a2_ff <= a1_ff;
         p2_ff <= p2_in;
      end
      if (rdy3) begin
         t3_ff <= t2_ff;
         a3_ff <= a2_ff;
         q3_ff <= q3_in;
      end
      if (rdy4) begin
         t4_ff <= t3_ff;
         a4_ff <= a3_ff;
         q4_ff <= q3_ff;
         hund4_ff <= hund4_in;
         tens4_ff <= tens4_in;
         units4_ff <= units4_in;
      end
   end

   // display scan: samples refresh the codes, ticks drive the next one
   always_comb begin
      for (int i = 0; i < vabd_pkg::NumDigits; i++) begin
         codes_in[i] = codes_ff[i];
      end
      scan_in = scan_ff;
      driven_in = driven_ff;
      scan_pick = (scan_ff == 2'd3) ? 2'd0 : scan_ff;
      rsp_in = rsp_ff;
      if (v4_ff && rdy_out) begin
         if (t4_ff == vabd_pkg::REQ_TICK) begin
            driven_in = codes_ff[scan_pick];
            scan_in = scan_pick + 2'd1;
         end else begin
            codes_in[0] = vabd_pkg::SelUnits | {4'd0, units4_ff};
            codes_in[1] = vabd_pkg::SelTens | {4'd0, tens4_ff};
            codes_in[2] = vabd_pkg::SelHundreds | {6'd0, hund4_ff};
         end
         rsp_in.port_value = driven_in;
         rsp_in.average = a4_ff;
         rsp_in.tenths = q4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vabd_pkg::NumDigits; i++) begin
            codes_ff[i] <= vabd_pkg::DigitReset;
         end
         scan_ff <= 2'd0;
         driven_ff <= '0;
      end else begin
         for (int i = 0; i < vabd_pkg::NumDigits; i++) begin
            codes_ff[i] <= codes_in[i];
         end
         scan_ff <= scan_in;
         driven_ff <= driven_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire
